@@ rtl/lsbp_pkg.sv @@
// ----------------------------------------------------------------------------
// lsbp_pkg
// shared constants and types for the lsb-first bit packer
// ----------------------------------------------------------------------------
package lsbp_pkg;

  localparam int WORD_BITS_DEF = 64;

  localparam int VALUE_W  = 64;
  localparam int BITCNT_W = 7;
  localparam int BYTE_W   = 8;
  localparam int MSG_W    = 13;
  localparam int PCNT_W   = 3;
  localparam int PBITS_W  = 7;

  localparam logic [MSG_W-1:0] COUNT_MAX = 13'h1fff;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // per-item control kept next to the buffered bytes
  typedef struct packed {
    logic             flush;
    logic             byte_valid;
    logic [MSG_W-1:0] msg;
  } obuf_ctl_t;

endpackage

@@ rtl/lsbp_lane.sv @@
// ----------------------------------------------------------------------------
// lsbp_lane
// one byte lane: byte LANE_IDX of the pending bits joined with the new field
// ----------------------------------------------------------------------------
module lsbp_lane #(
  parameter int LANE_IDX = 0,
  parameter int VM_W     = 72
) (
  input  logic [VM_W-1:0]                vm,
  input  logic [lsbp_pkg::PBITS_W-1:0]   pend_bits,
  input  logic [lsbp_pkg::PCNT_W-1:0]    pend_cnt,
  output logic [lsbp_pkg::BYTE_W-1:0]    lane_byte
);

  logic [15:0] win;
  logic [15:0] shifted;

  // window holds this byte of the field and the one below it
  assign shifted = win << pend_cnt;

  generate
    if (LANE_IDX == 0) begin : g_first
      assign win       = {vm[7:0], 8'h00};
      assign lane_byte = shifted[15:8] | {1'b0, pend_bits};
    end else begin : g_other
      assign win       = vm[8*LANE_IDX-8 +: 16];
      assign lane_byte = shifted[15:8];
    end
  endgenerate

endmodule

@@ rtl/lsbp_obuf.sv @@
// ----------------------------------------------------------------------------
// lsbp_obuf
// merge stage: holds the bytes of one item and hands them out, while out_ready is high, one per cycle
// ----------------------------------------------------------------------------
module lsbp_obuf #(
  parameter int LANES = 8,
  parameter int CNT_W = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               load,
  input  logic [CNT_W-1:0]                   load_cnt,
  input  logic [LANES-1:0][7:0]              load_bytes,
  input  lsbp_pkg::obuf_ctl_t                load_ctl,
  output logic                               load_ok,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [lsbp_pkg::BYTE_W-1:0]        out_out_byte,
  output logic                               out_byte_valid,
  output logic                               out_last,
  output logic [lsbp_pkg::MSG_W-1:0]         out_message_bytes
);

  logic [LANES-1:0][7:0] bytes_r, bytes_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  lsbp_pkg::obuf_ctl_t   ctl_r, ctl_nxt;
  logic                  pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  // room when empty or the last byte leaves this cycle
  assign load_ok   = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_ready);

  always_comb begin
    bytes_nxt = bytes_r;
    cnt_nxt   = cnt_r;
    ctl_nxt   = ctl_r;
    if (load) begin
      bytes_nxt = load_bytes;
      cnt_nxt   = load_cnt;
      ctl_nxt   = load_ctl;
    end else if (pop) begin
      bytes_nxt = bytes_r >> 8;
      cnt_nxt   = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
    ctl_r   <= ctl_nxt;
  end

  assign out_out_byte      = bytes_r[0];
  assign out_byte_valid    = ctl_r.flush ? ctl_r.byte_valid : 1'b1;
  assign out_last          = ctl_r.flush;
  assign out_message_bytes = ctl_r.flush ? ctl_r.msg : '0;

endmodule

@@ rtl/lsb_first_bit_packer.sv @@
// ----------------------------------------------------------------------------
// lsb_first_bit_packer
// packs 0..64 bit fields lsb first into a byte stream, flush closes a message
// ----------------------------------------------------------------------------
// output: first byte of an item is on the output in the cycle after acceptance
// throughput: an item yields 0..8 bytes, one per cycle while out_ready is high;
//   a new item is taken as the last byte leaves; an item with no byte adds none
// reset: synchronous active low, clears pending bits, bit count, byte count
//   and the output buffer; no clearing pass
module lsb_first_bit_packer #(
  parameter int WORD_BITS = lsbp_pkg::WORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_op,
  input  logic [lsbp_pkg::VALUE_W-1:0]       in_value,
  input  logic [lsbp_pkg::BITCNT_W-1:0]      in_bit_count,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [lsbp_pkg::BYTE_W-1:0]        out_out_byte,
  output logic                               out_byte_valid,
  output logic                               out_last,
  output logic [lsbp_pkg::MSG_W-1:0]         out_message_bytes
);

  // number of lanes = most bytes one field can complete
  localparam int LANES = (WORD_BITS + 7) / 8;
  localparam int CNT_W = $clog2(LANES + 1);
  localparam int VM_W  = 8 * (LANES + 1);
  localparam logic [lsbp_pkg::BITCNT_W-1:0] WB_SAT = lsbp_pkg::BITCNT_W'(WORD_BITS);

  // packer state
  logic [lsbp_pkg::PBITS_W-1:0] pend_bits_r, pend_bits_nxt;
  logic [lsbp_pkg::PCNT_W-1:0]  pend_cnt_r, pend_cnt_nxt;
  logic [lsbp_pkg::MSG_W-1:0]   sent_r, sent_nxt;

  logic                              in_acc;
  logic [lsbp_pkg::BITCNT_W-1:0]     n_sat;
  logic [7:0]                        total;
  logic [CNT_W-1:0]                  nbytes;
  logic [VM_W-1:0]                   vm;
  logic [LANES:0][7:0]               lane_bytes;
  logic [lsbp_pkg::MSG_W:0]          sent_sum;
  logic [lsbp_pkg::MSG_W-1:0]        sent_add;
  logic [lsbp_pkg::MSG_W-1:0]        sent_inc;

  logic                              load_ok;
  logic [CNT_W-1:0]                  load_cnt;
  logic [LANES-1:0][7:0]             load_bytes;
  lsbp_pkg::obuf_ctl_t               load_ctl;

  assign in_ready = load_ok;
  assign in_acc   = in_valid && in_ready;

  // oversized counts clamp to the word size
  assign n_sat  = (in_bit_count > WB_SAT) ? WB_SAT : in_bit_count;
  assign total  = 8'(pend_cnt_r) + 8'(n_sat);
  assign nbytes = CNT_W'(total[7:3]);

  // field with bits above the count forced to zero, padded for the top lane
  genvar gi;
  generate
    for (gi = 0; gi < VM_W; gi++) begin : g_mask
      if (gi < WORD_BITS) begin : g_in
        assign vm[gi] = in_value[gi] & (7'(gi) < n_sat);
      end else begin : g_pad
        assign vm[gi] = 1'b0;
      end
    end
  endgenerate

  // one lane per output byte plus one; the lane after the last whole byte gives the leftover
  generate
    for (gi = 0; gi <= LANES; gi++) begin : g_lane
      lsbp_lane #(
        .LANE_IDX (gi),
        .VM_W     (VM_W)
      ) u_lane (
        .vm        (vm),
        .pend_bits (pend_bits_r),
        .pend_cnt  (pend_cnt_r),
        .lane_byte (lane_bytes[gi])
      );
    end
  endgenerate

  // message byte count, saturating
  assign sent_sum = {1'b0, sent_r} + (lsbp_pkg::MSG_W + 1)'(nbytes);
  assign sent_add = (sent_sum > {1'b0, lsbp_pkg::COUNT_MAX}) ?
                    lsbp_pkg::COUNT_MAX : sent_sum[lsbp_pkg::MSG_W-1:0];
  assign sent_inc = (sent_r == lsbp_pkg::COUNT_MAX) ? sent_r : sent_r + 1'b1;

  // state update and what goes into the output buffer
  always_comb begin
    pend_bits_nxt = pend_bits_r;
    pend_cnt_nxt  = pend_cnt_r;
    sent_nxt      = sent_r;
    load_cnt      = nbytes;
    load_bytes    = lane_bytes[LANES-1:0];
    load_ctl      = '0;
    if (in_op == lsbp_pkg::OP_FLUSH) begin
      // a flush always gives exactly one item, padded byte or empty marker
      load_cnt         = CNT_W'(1);
      load_bytes       = '0;
      load_ctl.flush   = 1'b1;
      if (pend_cnt_r != '0) begin
        load_bytes[0]       = {1'b0, pend_bits_r};
        load_ctl.byte_valid = 1'b1;
        load_ctl.msg        = sent_inc;
      end else begin
        load_ctl.byte_valid = 1'b0;
        load_ctl.msg        = sent_r;
      end
    end
    if (in_acc) begin
      if (in_op == lsbp_pkg::OP_FLUSH) begin
        pend_bits_nxt = '0;
        pend_cnt_nxt  = '0;
        sent_nxt      = '0;
      end else begin
        pend_bits_nxt = lane_bytes[nbytes][lsbp_pkg::PBITS_W-1:0];
        pend_cnt_nxt  = total[2:0];
        sent_nxt      = sent_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
      sent_r      <= '0;
    end else begin
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      sent_r      <= sent_nxt;
    end
  end

  // merge stage: serializes the lane bytes onto the result channel
  lsbp_obuf #(
    .LANES (LANES),
    .CNT_W (CNT_W)
  ) u_obuf (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (in_acc),
    .load_cnt          (load_cnt),
    .load_bytes        (load_bytes),
    .load_ctl          (load_ctl),
    .load_ok           (load_ok),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_out_byte      (out_out_byte),
    .out_byte_valid    (out_byte_valid),
    .out_last          (out_last),
    .out_message_bytes (out_message_bytes)
  );

  // a flush leaves the packer empty
  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_op == lsbp_pkg::OP_FLUSH) |=> (pend_cnt_r == '0) && (sent_r == '0))
    else $error("flush did not clear packer state");

  // writes never lower the byte count
  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_op == lsbp_pkg::OP_WRITE) |=> sent_r >= $past(sent_r))
    else $error("byte count went down on a write");

  // partial byte holds no bits above the pending count
  assert property (@(posedge clk) disable iff (!rst_n)
    (pend_bits_r >> pend_cnt_r) == '0)
    else $error("stray bits above pending count");

  // a flush item is shown alone: first result after it is marked last
  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_op == lsbp_pkg::OP_FLUSH) |=> out_valid && out_last)
    else $error("flush result not presented");

endmodule
